// File: src/asrf_pkg.sv
// Shared types and constants for the audio silence run finder.
// Holds the frame and result words, the configuration bundle and register indexes.
// No dependencies.
package asrf_pkg;

    // Field widths of the frame and result words.
    localparam int SAMPLE_BITS    = 24;
    localparam int INDEX_BITS     = 32;
    localparam int RUN_BITS       = 32;
    localparam int MAX_CHANNELS   = 2;
    localparam int CHAN_CNT_BITS  = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Width used to compare a run span against the minimum length.
    localparam int CMP_BITS = (INDEX_BITS > RUN_BITS) ? INDEX_BITS : RUN_BITS;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH0_LOW       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH0_HIGH      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_LOW       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_HIGH      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS_USED = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RUN       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BACKWARDS     = 3'd6;

    // Reset values of the non-zero registers.
    localparam logic [CHAN_CNT_BITS-1:0] CHANNELS_USED_RESET = 2'd1;
    localparam logic [RUN_BITS-1:0]      MIN_RUN_RESET       = 32'd1;

    // One input frame.
    typedef struct packed {
        logic                          restart;
        logic [INDEX_BITS-1:0]         sample_index;
        logic signed [SAMPLE_BITS-1:0] value_ch0;
        logic signed [SAMPLE_BITS-1:0] value_ch1;
    } in_word_t;

    // One result.
    typedef struct packed {
        logic                  found;
        logic [INDEX_BITS-1:0] silence_start;
        logic                  in_run;
    } out_word_t;

    // Decoded configuration handed to the run tracker.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ch0_low;
        logic signed [SAMPLE_BITS-1:0] ch0_high;
        logic signed [SAMPLE_BITS-1:0] ch1_low;
        logic signed [SAMPLE_BITS-1:0] ch1_high;
        logic                          check_ch1;
        logic [RUN_BITS-1:0]           min_run;
        logic                          backwards;
    } cfg_t;

endpackage

// File: src/asrf_cfg.sv
// Configuration register file of the audio silence run finder.
// Depends on asrf_pkg for register indexes and the cfg_t bundle.
module asrf_cfg
    import asrf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    logic signed [SAMPLE_BITS-1:0] ch0_low_reg;
    logic signed [SAMPLE_BITS-1:0] ch0_high_reg;
    logic signed [SAMPLE_BITS-1:0] ch1_low_reg;
    logic signed [SAMPLE_BITS-1:0] ch1_high_reg;
    logic [CHAN_CNT_BITS-1:0]      channels_used_reg;
    logic [RUN_BITS-1:0]           min_run_reg;
    logic                          backwards_reg;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch0_low_reg       <= '0;
            ch0_high_reg      <= '0;
            ch1_low_reg       <= '0;
            ch1_high_reg      <= '0;
            channels_used_reg <= CHANNELS_USED_RESET;
            min_run_reg       <= MIN_RUN_RESET;
            backwards_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CH0_LOW:       ch0_low_reg       <= cfg_data[SAMPLE_BITS-1:0];
                REG_CH0_HIGH:      ch0_high_reg      <= cfg_data[SAMPLE_BITS-1:0];
                REG_CH1_LOW:       ch1_low_reg       <= cfg_data[SAMPLE_BITS-1:0];
                REG_CH1_HIGH:      ch1_high_reg      <= cfg_data[SAMPLE_BITS-1:0];
                REG_CHANNELS_USED: channels_used_reg <= cfg_data[CHAN_CNT_BITS-1:0];
                REG_MIN_RUN:       min_run_reg       <= cfg_data[RUN_BITS-1:0];
                REG_BACKWARDS:     backwards_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // A count of zero acts as one; anything above one checks channel 1 too.
    always_comb
    begin
        cfg.ch0_low   = ch0_low_reg;
        cfg.ch0_high  = ch0_high_reg;
        cfg.ch1_low   = ch1_low_reg;
        cfg.ch1_high  = ch1_high_reg;
        cfg.check_ch1 = (MAX_CHANNELS > 1) && (channels_used_reg >= CHAN_CNT_BITS'(2));
        cfg.min_run   = min_run_reg;
        cfg.backwards = backwards_reg;
    end

endmodule

// File: src/asrf_core.sv
// Run tracker of the audio silence run finder: holds the open run and the found
// result, and works out the result of one frame. Depends on asrf_pkg.
module asrf_core
    import asrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_word_t  frame,
    input  cfg_t      cfg,
    output out_word_t result
);

    logic                  open_reg, open_next;
    logic [INDEX_BITS-1:0] start_reg, start_next;
    logic                  found_reg, found_next;
    logic [INDEX_BITS-1:0] found_idx_reg, found_idx_next;

    logic                  base_open;
    logic                  base_found;
    logic [INDEX_BITS-1:0] base_start;
    logic [INDEX_BITS-1:0] base_found_idx;
    logic                  ch0_silent;
    logic                  ch1_silent;
    logic [INDEX_BITS-1:0] run_start;
    logic [INDEX_BITS-1:0] span;
    logic                  order_ok;
    logic [RUN_BITS-1:0]   min_less_one;
    logic                  long_enough;

    always_comb
    begin
        // A restart clears the run and the result before the frame is handled.
        base_open      = frame.restart ? 1'b0 : open_reg;
        base_start     = frame.restart ? '0 : start_reg;
        base_found     = frame.restart ? 1'b0 : found_reg;
        base_found_idx = frame.restart ? '0 : found_idx_reg;

        // Window tests; an inverted window never matches.
        ch0_silent = (frame.value_ch0 >= cfg.ch0_low) && (frame.value_ch0 <= cfg.ch0_high);
        ch1_silent = (frame.value_ch1 >= cfg.ch1_low) && (frame.value_ch1 <= cfg.ch1_high);

        // The run starts at this frame if none is open yet.
        run_start = base_open ? base_start : frame.sample_index;

        // Run length check in the search direction.
        if (cfg.backwards)
        begin
            order_ok = run_start >= frame.sample_index;
            span     = run_start - frame.sample_index;
        end
        else
        begin
            order_ok = frame.sample_index >= run_start;
            span     = frame.sample_index - run_start;
        end
        min_less_one = cfg.min_run - RUN_BITS'(1);
        long_enough  = (cfg.min_run == '0) ||
                       (order_ok && (CMP_BITS'(span) >= CMP_BITS'(min_less_one)));

        open_next      = base_open;
        start_next     = base_start;
        found_next     = base_found;
        found_idx_next = base_found_idx;

        // Channel 0 decides opening and completion. Channel 1 sees the same
        // run and index, so it can only close the run.
        if (!base_found)
        begin
            if (!ch0_silent)
            begin
                open_next = 1'b0;
            end
            else
            begin
                open_next  = 1'b1;
                start_next = run_start;
                if (long_enough)
                begin
                    found_next     = 1'b1;
                    found_idx_next = run_start;
                end
                else if (cfg.check_ch1 && !ch1_silent)
                begin
                    open_next = 1'b0;
                end
            end
        end

        result.found         = found_next;
        result.silence_start = found_next ? found_idx_next : '0;
        result.in_run        = open_next;
    end

    // Run state advances once per frame handed to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            start_reg     <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
        end
        else if (step_en)
        begin
            open_reg      <= open_next;
            start_reg     <= start_next;
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
        end
    end

endmodule

// File: src/audio_silence_run_finder.sv
// Top level of the audio silence run finder: input and result registers with
// their handshakes. Depends on asrf_pkg, asrf_cfg and asrf_core.
//
// The block takes one audio frame per clock cycle while the output side keeps taking
// words, and returns one result word per frame, in order. A frame is accepted into
// the input register, and its result is loaded into the result register when the
// frame moves on, that is when the result register is free or being drained. The
// rate is set by the run-state update in the tracker, which is combinational between
// its registers, so frames may follow back to back. When a result word waits, the
// input register fills and in_ready follows out_ready, so at most two frames are
// held. Configuration is written through a plain write port and should only change
// while no frame is in flight.
module audio_silence_run_finder
    import asrf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_word_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_word_t                 out_data,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t      cfg;
    in_word_t  in_data_reg;
    logic      in_valid_reg;
    out_word_t out_data_reg;
    logic      out_valid_reg;
    out_word_t step_result;
    logic      advance;
    logic      in_take;

    asrf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asrf_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .frame   (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // The held frame moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: bench/audio_silence_run_finder_tb.sv
// Self-checking testbench for audio_silence_run_finder: streams audio frames and checks each result.
// A scoreboard class predicts every result word from its own copy of the settings and run state.
// Depends on asrf_pkg and the audio_silence_run_finder RTL.
module audio_silence_run_finder_tb
    import asrf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 400_000;
    localparam int RAND_PHASES      = 8;
    localparam int FRAMES_PER_PHASE = 106;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER  = 400;
    localparam int SMP_MIN          = -8388608;
    localparam int SMP_MAX          = 8388607;

    // Predicts the run tracker and checks each result word against it.
    class silence_scoreboard;
        logic signed [SAMPLE_BITS-1:0] lo [MAX_CHANNELS];
        logic signed [SAMPLE_BITS-1:0] hi [MAX_CHANNELS];
        logic [CHAN_CNT_BITS-1:0]      chan_cnt;
        logic [RUN_BITS-1:0]           min_len;
        logic                          search_down;
        logic                          run_open;
        logic [INDEX_BITS-1:0]         run_start;
        logic                          found;
        logic [INDEX_BITS-1:0]         found_at;
        out_word_t                     expected_q [$];
        int                            frames;
        int                            results;
        int                            finds;
        int                            errors;

        function new();
            lo[0]       = '0;
            lo[1]       = '0;
            hi[0]       = '0;
            hi[1]       = '0;
            chan_cnt    = CHANNELS_USED_RESET;
            min_len     = MIN_RUN_RESET;
            search_down = 1'b0;
            run_open    = 1'b0;
            run_start   = '0;
            found       = 1'b0;
            found_at    = '0;
            frames      = 0;
            results     = 0;
            finds       = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
            case (idx)
                REG_CH0_LOW:       lo[0] = d[SAMPLE_BITS-1:0];
                REG_CH0_HIGH:      hi[0] = d[SAMPLE_BITS-1:0];
                REG_CH1_LOW:       lo[1] = d[SAMPLE_BITS-1:0];
                REG_CH1_HIGH:      hi[1] = d[SAMPLE_BITS-1:0];
                REG_CHANNELS_USED: chan_cnt = d[CHAN_CNT_BITS-1:0];
                REG_MIN_RUN:       min_len = d[RUN_BITS-1:0];
                REG_BACKWARDS:     search_down = d[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // True when the open run, measured in the search direction, is long enough.
        function bit long_enough(logic [INDEX_BITS-1:0] idx);
            logic [INDEX_BITS-1:0] span;
            if (min_len == '0)
                return 1'b1;
            if (search_down) begin
                if (run_start < idx)
                    return 1'b0;
                span = run_start - idx;
            end
            else begin
                if (idx < run_start)
                    return 1'b0;
                span = idx - run_start;
            end
            return span >= (min_len - 1'b1);
        endfunction

        // Advances the predicted run state by one accepted frame.
        function void note_frame(in_word_t w);
            logic signed [SAMPLE_BITS-1:0] v [MAX_CHANNELS];
            int                            nch;
            out_word_t                     e;
            frames++;
            v[0] = w.value_ch0;
            v[1] = w.value_ch1;
            if (w.restart) begin
                run_open  = 1'b0;
                run_start = '0;
                found     = 1'b0;
                found_at  = '0;
            end
            nch = (chan_cnt == 0) ? 1 : ((chan_cnt > MAX_CHANNELS) ? MAX_CHANNELS : chan_cnt);
            if (!found) begin
                for (int c = 0; c < nch; c++) begin
                    if (v[c] < lo[c] || v[c] > hi[c]) begin
                        run_open = 1'b0;
                        break;
                    end
                    if (!run_open) begin
                        run_open  = 1'b1;
                        run_start = w.sample_index;
                    end
                    if (long_enough(w.sample_index)) begin
                        found    = 1'b1;
                        found_at = run_start;
                        finds++;
                        break;
                    end
                end
            end
            e.found         = found;
            e.silence_start = found ? found_at : '0;
            e.in_run        = run_open;
            expected_q.push_back(e);
        endfunction

        // Compares one accepted result word with the oldest prediction.
        function void check_result(out_word_t got);
            out_word_t e;
            results++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result word: found=%0b start=%h in_run=%0b",
                             $realtime, got.found, got.silence_start, got.in_run);
                return;
            end
            e = expected_q.pop_front();
            if (got.found !== e.found || got.silence_start !== e.silence_start ||
                got.in_run !== e.in_run) begin
                errors++;
                if (errors <= 10) begin
                    $display("[%0t] result %0d: expected found=%0b start=%h in_run=%0b",
                             $realtime, results, e.found, e.silence_start, e.in_run);
                    $display("    got found=%0b start=%h in_run=%0b",
                             got.found, got.silence_start, got.in_run);
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    in_word_t                  in_data;
    logic                      out_valid;
    logic                      out_ready;
    out_word_t                 out_data;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    silence_scoreboard     sb;
    bit                    calm;
    int                    cycle_count;
    int                    settings_count;
    logic [INDEX_BITS-1:0] idx_cursor;

    audio_silence_run_finder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // Handshake monitor: every accepted frame feeds the predictor, every word is checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_frame(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // Result receiver: random stall bursts, one long hold-off that backs up the input.
    initial
    begin : sink_drive
        int n;
        bit held_long;
        held_long = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held_long && sb.frames >= LONG_HOLD_AFTER) begin
                held_long = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else begin
                n = $urandom_range(1, 24);
                out_ready <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // Offers one frame, after an optional idle burst, and returns once it is accepted.
    task automatic send_frame(input in_word_t w);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // Drops valid and waits until every predicted word has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] d);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Writes the whole register set; sample windows go in sign-extended.
    task automatic load_settings(input int lo0, input int hi0, input int lo1, input int hi1,
                                 input int cnt, input logic [31:0] minr, input bit down);
        write_reg(REG_CH0_LOW, 32'(lo0));
        write_reg(REG_CH0_HIGH, 32'(hi0));
        write_reg(REG_CH1_LOW, 32'(lo1));
        write_reg(REG_CH1_HIGH, 32'(hi1));
        write_reg(REG_CHANNELS_USED, 32'(cnt));
        write_reg(REG_MIN_RUN, minr);
        write_reg(REG_BACKWARDS, 32'(down));
        settings_count++;
    endtask

    function automatic in_word_t mk_frame(bit rs, logic [INDEX_BITS-1:0] idx, int v0, int v1);
        in_word_t w;
        w.restart      = rs;
        w.sample_index = idx;
        w.value_ch0    = SAMPLE_BITS'(v0);
        w.value_ch1    = SAMPLE_BITS'(v1);
        return w;
    endfunction

    // Mostly silent samples inside the channel window, with edges and loud outliers.
    function automatic logic signed [SAMPLE_BITS-1:0] make_sample(int c);
        int l;
        int h;
        int r;
        l = sb.lo[c];
        h = sb.hi[c];
        r = $urandom_range(0, 39);
        if (r < 2 || l > h)
            return SAMPLE_BITS'($urandom);
        if (r == 2)
            return SAMPLE_BITS'(l - 1);
        if (r == 3)
            return SAMPLE_BITS'(h + 1);
        if (r == 4)
            return SAMPLE_BITS'(l);
        if (r == 5)
            return SAMPLE_BITS'(h);
        return SAMPLE_BITS'(l + int'($urandom_range(0, h - l)));
    endfunction

    // Next frame of a sequence that walks the index in the search direction.
    function automatic in_word_t next_random_frame(input bit first);
        in_word_t              w;
        int                    r;
        logic [INDEX_BITS-1:0] rim_base;
        r = $urandom_range(0, 99);
        w.restart = first || (sb.found ? (r < 25) : (r < 4));
        r = $urandom_range(0, 29);
        if (w.restart && r < 15) begin
            rim_base   = $urandom_range(0, 1) ? 32'hFFFF_FFF8 : 32'd0;
            idx_cursor = (r < 4) ? rim_base + $urandom_range(0, 7) : 32'($urandom);
        end
        else if (r == 0)
            idx_cursor = $urandom;
        else if (r == 1)
            idx_cursor = sb.search_down ? idx_cursor + $urandom_range(1, 3)
                                        : idx_cursor - $urandom_range(1, 3);
        else
            idx_cursor = sb.search_down ? idx_cursor - 1'b1 : idx_cursor + 1'b1;
        w.sample_index = idx_cursor;
        w.value_ch0    = make_sample(0);
        w.value_ch1    = make_sample(1);
        return w;
    endfunction

    // Random register set: full, inverted or narrow windows; short minimum runs mostly.
    task automatic random_settings();
        int          wlo [2];
        int          whi [2];
        int          kind;
        int          center;
        int          hw;
        logic [31:0] minr;
        for (int c = 0; c < 2; c++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                wlo[c] = SMP_MIN;
                whi[c] = SMP_MAX;
            end
            else if (kind == 1) begin
                whi[c] = -int'($urandom_range(0, 8388608));
                wlo[c] = whi[c] + int'($urandom_range(1, 5000));
            end
            else begin
                center = int'($urandom_range(0, 16777215)) - 8388608;
                hw     = $urandom_range(0, 3000);
                wlo[c] = (center - hw < SMP_MIN) ? SMP_MIN : center - hw;
                whi[c] = (center + hw > SMP_MAX) ? SMP_MAX : center + hw;
            end
        end
        kind = $urandom_range(0, 7);
        if (kind == 0)
            minr = 32'hFFFF_FFFF;
        else if (kind == 1)
            minr = $urandom;
        else
            minr = $urandom_range(0, 10);
        load_settings(wlo[0], whi[0], wlo[1], whi[1], $urandom_range(0, 3), minr,
                      1'($urandom_range(0, 1)));
    endtask

    // Main sequence: reset, directed corner cases, then random phases.
    initial
    begin
        sb             = new();
        calm           = 1'b0;
        cycle_count    = 0;
        settings_count = 0;
        idx_cursor     = '0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_CH0_LOW;
        cfg_data       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a zero value is silent and a run of one is enough; then sticky.
        send_frame(mk_frame(1'b0, 32'd5, 0, 0));
        send_frame(mk_frame(1'b0, 32'd6, 100, 0));
        send_frame(mk_frame(1'b1, 32'hFFFF_FFFF, SMP_MIN, SMP_MAX));

        // Channel count above the maximum, a loud channel 1 closing the run,
        // and an index that lies before the run start.
        wait_drained();
        load_settings(SMP_MIN, SMP_MAX, -10, 10, 3, 32'd3, 1'b0);
        send_frame(mk_frame(1'b1, 32'd10, SMP_MAX, SMP_MIN));
        send_frame(mk_frame(1'b0, 32'd11, SMP_MIN, 5));
        send_frame(mk_frame(1'b0, 32'd12, 0, -10));
        send_frame(mk_frame(1'b0, 32'd9, 0, 10));
        send_frame(mk_frame(1'b0, 32'd13, 0, 0));

        // Inverted channel 0 window: nothing is silent even with a zero minimum.
        wait_drained();
        load_settings(5, -5, SMP_MIN, SMP_MAX, 0, 32'd0, 1'b1);
        send_frame(mk_frame(1'b1, 32'd100, 0, 0));
        send_frame(mk_frame(1'b0, 32'd101, 5, 0));

        // Zero channel count acts as one; a zero minimum is met at once.
        wait_drained();
        load_settings(-5, 5, SMP_MAX, SMP_MAX, 0, 32'd0, 1'b0);
        send_frame(mk_frame(1'b1, 32'd0, -5, SMP_MIN));
        send_frame(mk_frame(1'b0, 32'd7, 1000, 0));

        // Backward search with a frame behind the run start on the way.
        wait_drained();
        load_settings(-5, 5, SMP_MIN, SMP_MAX, 2, 32'd4, 1'b1);
        send_frame(mk_frame(1'b1, 32'hFFFF_FFF0, 5, SMP_MIN));
        send_frame(mk_frame(1'b0, 32'hFFFF_FFEF, -5, SMP_MAX));
        send_frame(mk_frame(1'b0, 32'hFFFF_FFF5, 0, 0));
        send_frame(mk_frame(1'b0, 32'hFFFF_FFEE, 0, 0));
        send_frame(mk_frame(1'b0, 32'hFFFF_FFED, 0, 0));

        // Largest minimum run, met only across the whole index range.
        wait_drained();
        load_settings(SMP_MIN, SMP_MIN, SMP_MAX, SMP_MAX, 2, 32'hFFFF_FFFF, 1'b0);
        send_frame(mk_frame(1'b1, 32'd0, SMP_MIN, SMP_MAX));
        send_frame(mk_frame(1'b0, 32'hFFFF_FFFF, SMP_MIN, SMP_MAX));

        // Random phases; the last one runs without idling on either side.
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            if (p == RAND_PHASES - 1)
                calm = 1'b1;
            random_settings();
            idx_cursor = $urandom;
            for (int k = 0; k < FRAMES_PER_PHASE; k++)
                send_frame(next_random_frame(k == 0));
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Run covered %0d frames under %0d register settings in %0d cycles.",
                 sb.frames, settings_count, cycle_count);
        $display("%0d result words checked, %0d silent runs reached the minimum, %0d bad words.",
                 sb.results, sb.finds, sb.errors);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: audio_silence_run_finder.f
src/asrf_pkg.sv
src/asrf_cfg.sv
src/asrf_core.sv
src/audio_silence_run_finder.sv
bench/audio_silence_run_finder_tb.sv
